[rtl/bnf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnf_pkg
// Shared types, codes and constants of the 3x3 binary neighborhood filter.
// ----------------------------------------------------------------------------
package bnf_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int WIDTH_RST     = 1024;
    localparam int HEIGHT_RST    = 1;

    localparam int WIDTH_W       = 11;
    localparam int HEIGHT_W      = 16;
    localparam int MODE_W        = 3;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;

    localparam int SIGMA_W       = 4;
    localparam int SIGMA_FULL    = 8;
    localparam int NOIZE_LOW     = 2;
    localparam int NOIZE_HIGH    = 6;
    localparam int SIGMA_NONE    = 0;

    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [MODE_W-1:0] {
        MODE_SHRINK = 3'd0,
        MODE_EXPAND = 3'd1,
        MODE_EDGE   = 3'd2,
        MODE_SALT   = 3'd3,
        MODE_PEPPER = 3'd4,
        MODE_NOISE  = 3'd5,
        MODE_NOIZE  = 3'd6
    } t_filter_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILTER_MODE  = 2'd0,
        CFG_IMAGE_WIDTH  = 2'd1,
        CFG_IMAGE_HEIGHT = 2'd2
    } t_cfg_reg;

    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_DRAIN = 1'b1
    } t_cmd;

    typedef struct packed {
        logic upper;
        logic middle;
    } t_ls_bits;

    typedef struct packed {
        logic pixel_out;
        logic last_of_frame;
    } t_out_item;

endpackage

[rtl/bnf_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnf channel interfaces
// Valid/ready channels for input pixels, filtered pixels and register writes.
// ----------------------------------------------------------------------------
interface bnf_pix_in_if;
    logic valid;
    logic ready;
    logic cmd;
    logic pixel_in;

    modport source (output valid, output cmd, output pixel_in, input ready);
    modport sink   (input valid, input cmd, input pixel_in, output ready);
endinterface

interface bnf_pix_out_if;
    logic valid;
    logic ready;
    logic pixel_out;
    logic last_of_frame;

    modport source (output valid, output pixel_out, output last_of_frame, input ready);
    modport sink   (input valid, input pixel_out, input last_of_frame, output ready);
endinterface

interface bnf_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [bnf_pkg::CFG_IDX_W-1:0]   reg_index;
    logic [bnf_pkg::CFG_DATA_W-1:0]  wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

[rtl/bnf_line_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnf_line_store
// Upper and middle line memories, registered read, with write forwarding.
// ----------------------------------------------------------------------------
module bnf_line_store #(
    parameter int DEPTH = bnf_pkg::MAX_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  bnf_pkg::t_ls_bits        i_wr_data,
    output bnf_pkg::t_ls_bits        o_rd_data
);

    logic r_mem_upper  [DEPTH];
    logic r_mem_middle [DEPTH];

    bnf_pkg::t_ls_bits r_rd_data;
    bnf_pkg::t_ls_bits r_fwd_data;
    logic              r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_upper[i_wr_addr]  <= i_wr_data.upper;
            r_mem_middle[i_wr_addr] <= i_wr_data.middle;
        end
        if (i_rd_en) begin
            r_rd_data.upper  <= r_mem_upper[i_rd_addr];
            r_rd_data.middle <= r_mem_middle[i_rd_addr];
        end
        r_fwd_data <= i_wr_data;
    end

    // forward a write that lands on the edge of a read to the same entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : r_rd_data;

endmodule

[rtl/bnf_rule.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnf_rule
// Neighbor count and mode rule for one centre pixel.
// ----------------------------------------------------------------------------
module bnf_rule (
    input  logic [bnf_pkg::MODE_W-1:0] i_mode,
    input  logic                       i_border,
    input  logic                       i_centre,
    input  logic [7:0]                 i_neigh,
    output logic                       o_pixel
);

    logic [bnf_pkg::SIGMA_W-1:0] sigma;
    logic                        full;
    logic                        none;

    assign sigma = bnf_pkg::SIGMA_W'($countones(i_neigh));
    assign full  = sigma == bnf_pkg::SIGMA_W'(bnf_pkg::SIGMA_FULL);
    assign none  = sigma == bnf_pkg::SIGMA_W'(bnf_pkg::SIGMA_NONE);

    always_comb begin
        o_pixel = i_centre;
        if (i_border) begin
            if (i_mode == bnf_pkg::MODE_EDGE) begin
                o_pixel = 1'b0;
            end
        end else begin
            case (i_mode)
                bnf_pkg::MODE_SHRINK: begin
                    if (!full) o_pixel = 1'b0;
                end
                bnf_pkg::MODE_EXPAND: begin
                    if (!none) o_pixel = 1'b1;
                end
                bnf_pkg::MODE_EDGE, bnf_pkg::MODE_PEPPER: begin
                    if (full) o_pixel = 1'b0;
                end
                bnf_pkg::MODE_SALT: begin
                    if (full) o_pixel = 1'b1;
                end
                bnf_pkg::MODE_NOISE: begin
                    if (none) o_pixel = 1'b0;
                    else if (full) o_pixel = 1'b1;
                end
                bnf_pkg::MODE_NOIZE: begin
                    if (sigma < bnf_pkg::SIGMA_W'(bnf_pkg::NOIZE_LOW)) o_pixel = 1'b0;
                    else if (sigma > bnf_pkg::SIGMA_W'(bnf_pkg::NOIZE_HIGH)) o_pixel = 1'b1;
                end
                default: begin
                    o_pixel = i_centre;
                end
            endcase
        end
    end

endmodule

[rtl/bnf_out_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnf_out_fifo
// Small output queue that decouples the filter from the result sink.
// ----------------------------------------------------------------------------
module bnf_out_fifo (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    input  bnf_pkg::t_out_item                 i_item,
    bnf_pix_out_if.source                      o_pix,
    output logic [bnf_pkg::FIFO_CNT_W-1:0]     o_count
);

    bnf_pkg::t_out_item                r_mem [bnf_pkg::FIFO_DEPTH];
    logic [bnf_pkg::FIFO_PTR_W-1:0]    r_wptr;
    logic [bnf_pkg::FIFO_PTR_W-1:0]    r_rptr;
    logic [bnf_pkg::FIFO_CNT_W-1:0]    r_count;
    logic                              pop;

    assign o_pix.valid         = r_count != '0;
    assign o_pix.pixel_out     = r_mem[r_rptr].pixel_out;
    assign o_pix.last_of_frame = r_mem[r_rptr].last_of_frame;
    assign pop                 = o_pix.valid && o_pix.ready;
    assign o_count             = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wptr <= r_wptr + 1'b1;
            if (pop)    r_rptr <= r_rptr + 1'b1;
            if (i_push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[rtl/binary_neighbourhood_filter_3x3.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_neighbourhood_filter_3x3
// Streaming 3x3 binary filter (shrink, expand, edge, salt, pepper, noise,
// noize) over two line memories and a 3x3 window.
// ----------------------------------------------------------------------------
// The block takes one pixel or drain transfer per clock and keeps that rate
// as long as the result sink keeps up; a four-entry output queue absorbs
// short stalls. Each transfer reads both line memories at its column in the
// cycle it is accepted, and a pixel transfer writes them back in the next
// cycle, with a forward path when consecutive transfers hit the same column,
// so the memory port pair sets the one-per-clock figure. Results pass through
// the memory stage and the output queue and trail the input by one row plus
// one pixel; after the last pixel, one drain transfer per owed result flushes
// the frame and the final result carries last_of_frame. The line memories
// need no clearing after reset.
// ----------------------------------------------------------------------------
module binary_neighbourhood_filter_3x3 #(
    parameter int MAX_WIDTH = bnf_pkg::MAX_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bnf_pix_in_if.sink    i_pix,
    bnf_pix_out_if.source o_pix,
    bnf_cfg_if.sink       i_cfg
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = bnf_pkg::HEIGHT_W;
    localparam int W_RST  = (bnf_pkg::WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : bnf_pkg::WIDTH_RST;
    localparam logic [COL_W-1:0] WM1_RST = COL_W'(W_RST - 1);
    localparam logic [ROW_W-1:0] HM1_RST = ROW_W'(bnf_pkg::HEIGHT_RST - 1);

    // configuration
    logic [bnf_pkg::MODE_W-1:0] r_mode;
    logic [COL_W-1:0]           r_wm1;
    logic [ROW_W-1:0]           r_hm1;
    logic [COL_W-1:0]           n_wm1;
    logic [ROW_W-1:0]           n_hm1;
    logic [bnf_pkg::WIDTH_W-1:0]  cfg_w;
    logic [bnf_pkg::HEIGHT_W-1:0] cfg_h;
    logic                       cfg_acc;
    logic                       cfg_restart;

    // position counters
    logic [COL_W-1:0] r_in_col,  n_in_col;
    logic [ROW_W-1:0] r_in_row,  n_in_row;
    logic [COL_W-1:0] r_out_col, n_out_col;
    logic [ROW_W-1:0] r_out_row, n_out_row;

    // accept stage
    logic             acc;
    logic             in_full;
    logic             is_pix;
    logic             primed;
    logic             emit;
    logic             out_last_col;
    logic             out_last_row;
    logic             border;
    logic             last;
    logic [COL_W-1:0] rd_addr;

    // memory stage
    logic             r_s1_v;
    logic             r_s1_wr;
    logic             r_s1_emit;
    logic             r_s1_drain;
    logic             r_s1_use_mid;
    logic             r_s1_border;
    logic             r_s1_last;
    logic             r_s1_pix;
    logic [COL_W-1:0] r_s1_addr;
    logic [8:0]       r_window;
    logic [8:0]       n_window;

    bnf_pkg::t_ls_bits  rd_data;
    bnf_pkg::t_ls_bits  wr_data;
    bnf_pkg::t_out_item out_item;
    logic               centre;
    logic               s1_push;
    logic [bnf_pkg::FIFO_CNT_W-1:0] fifo_count;

    assign i_cfg.ready = 1'b1;
    assign cfg_acc     = i_cfg.valid && i_cfg.ready;
    assign cfg_w       = i_cfg.wr_data[bnf_pkg::WIDTH_W-1:0];
    assign cfg_h       = i_cfg.wr_data[bnf_pkg::HEIGHT_W-1:0];
    assign cfg_restart = cfg_acc && (i_cfg.reg_index == bnf_pkg::CFG_IMAGE_WIDTH ||
                                     i_cfg.reg_index == bnf_pkg::CFG_IMAGE_HEIGHT);

    always_comb begin
        if (cfg_w == '0) begin
            n_wm1 = '0;
        end else if (32'(cfg_w) > 32'(MAX_WIDTH)) begin
            n_wm1 = COL_W'(MAX_WIDTH - 1);
        end else begin
            n_wm1 = COL_W'(cfg_w - 1'b1);
        end
        n_hm1 = (cfg_h == '0) ? '0 : ROW_W'(cfg_h - 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= bnf_pkg::MODE_SHRINK;
            r_wm1  <= WM1_RST;
            r_hm1  <= HM1_RST;
        end else if (cfg_acc) begin
            case (i_cfg.reg_index)
                bnf_pkg::CFG_FILTER_MODE:  r_mode <= i_cfg.wr_data[bnf_pkg::MODE_W-1:0];
                bnf_pkg::CFG_IMAGE_WIDTH:  r_wm1  <= n_wm1;
                bnf_pkg::CFG_IMAGE_HEIGHT: r_hm1  <= n_hm1;
                default: begin
                end
            endcase
        end
    end

    // room for the transfer in flight and this one
    assign i_pix.ready = ({1'b0, fifo_count} + (bnf_pkg::FIFO_CNT_W+1)'(r_s1_v))
                         < (bnf_pkg::FIFO_CNT_W+1)'(bnf_pkg::FIFO_DEPTH);
    assign acc         = i_pix.valid && i_pix.ready;

    assign in_full      = r_in_row > r_hm1;
    assign is_pix       = !in_full && (i_pix.cmd == bnf_pkg::CMD_PIXEL);
    assign primed       = (r_in_row > ROW_W'(1)) || (r_in_row == ROW_W'(1) && r_in_col != '0);
    assign emit         = in_full || (is_pix && primed);
    assign out_last_col = r_out_col == r_wm1;
    assign out_last_row = r_out_row == r_hm1;
    assign border       = r_out_col == '0 || r_out_row == '0 || out_last_col || out_last_row;
    assign last         = out_last_col && out_last_row;
    assign rd_addr      = in_full ? r_out_col : r_in_col;

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (acc && is_pix) begin
            if (r_in_col == r_wm1) begin
                n_in_col = '0;
                n_in_row = r_in_row + 1'b1;
            end else begin
                n_in_col = r_in_col + 1'b1;
            end
        end
        if (acc && emit) begin
            if (last) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else if (out_last_col) begin
                n_out_col = '0;
                n_out_row = r_out_row + 1'b1;
            end else begin
                n_out_col = r_out_col + 1'b1;
            end
        end
        if (cfg_restart) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_s1_v    <= 1'b0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_s1_v    <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_wr      <= is_pix;
            r_s1_emit    <= emit;
            r_s1_drain   <= in_full;
            r_s1_use_mid <= out_last_row;
            r_s1_border  <= border;
            r_s1_last    <= last;
            r_s1_pix     <= i_pix.pixel_in;
            r_s1_addr    <= rd_addr;
        end
    end

    bnf_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (acc),
        .i_rd_addr (rd_addr),
        .i_wr_en   (r_s1_v && r_s1_wr),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    // shift the middle row up, store the new pixel in the middle row
    assign wr_data.upper  = rd_data.middle;
    assign wr_data.middle = r_s1_pix;
    assign n_window       = {r_window[5:0], r_s1_pix, rd_data.middle, rd_data.upper};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
        end else if (r_s1_v && r_s1_wr) begin
            r_window <= n_window;
        end
    end

    assign centre = r_s1_drain ? (r_s1_use_mid ? rd_data.middle : rd_data.upper)
                               : n_window[4];

    bnf_rule u_rule (
        .i_mode   (r_mode),
        .i_border (r_s1_border),
        .i_centre (centre),
        .i_neigh  ({n_window[8:5], n_window[3:0]}),
        .o_pixel  (out_item.pixel_out)
    );

    assign out_item.last_of_frame = r_s1_last;
    assign s1_push                = r_s1_v && r_s1_emit;

    bnf_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s1_push),
        .i_item  (out_item),
        .o_pix   (o_pix),
        .o_count (fifo_count)
    );

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && emit && last) |=>
        (r_in_col == '0 && r_in_row == '0 && r_out_col == '0 && r_out_row == '0))
        else $error("frame counters not cleared after last result");

    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, fifo_count} + (bnf_pkg::FIFO_CNT_W+1)'(r_s1_v))
        <= (bnf_pkg::FIFO_CNT_W+1)'(bnf_pkg::FIFO_DEPTH))
        else $error("output queue overcommitted");

    a_drain_on_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && r_s1_drain) |-> (r_s1_border && r_s1_emit && !r_s1_wr))
        else $error("drain transfer off the border or without a result");

endmodule
